[hdl/tctt_pkg.sv]
// Package for the tick count to time converter.
// Holds the transaction type passed from front to back, register indexes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tctt_pkg;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned RATE_W = 34;

	// configuration register indexes
	localparam logic REG_START_COUNT = 1'b0;
	localparam logic REG_TICK_RATE   = 1'b1;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000000);
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [9:0]  NS_PER_US  = 10'd1000;

	// ceil(2^36 / 1000): exact quotient by 1000 for any value below 2^26 after >> 36
	localparam logic [26:0] US_RECIP = 27'd68719477;

	// one queued transaction: elapsed ticks and the rate it is to be divided by
	typedef struct packed {
		logic [DATA_W-1:0] ticks;
		logic [RATE_W-1:0] rate;
	} item_t;
endpackage
`default_nettype wire

[hdl/tctt_front.sv]
// Front end: configuration registers, start count subtraction, rate clamping.
// Depends on tctt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tctt_front
	import tctt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [DATA_W-1:0] cfg_wdata,
	input  wire logic [DATA_W-1:0] counter_value,
	output item_t                  item
);
	logic [DATA_W-1:0] start_count_q;
	logic [RATE_W-1:0] tick_rate_q;
	logic [COUNT_WIDTH-1:0] diff;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_count_q <= '0;
			tick_rate_q   <= RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_COUNT: start_count_q <= cfg_wdata;
				REG_TICK_RATE:   tick_rate_q   <= cfg_wdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// elapsed ticks wrap at the counter width; a zero rate counts as one
	assign diff = counter_value[COUNT_WIDTH-1:0] - start_count_q[COUNT_WIDTH-1:0];
	assign item.ticks = DATA_W'(diff);
	assign item.rate  = (tick_rate_q == '0) ? RATE_W'(1) : tick_rate_q;
endmodule
`default_nettype wire

[hdl/tctt_queue.sv]
// Two-entry queue between front and back ends.
// Depends on tctt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tctt_queue
	import tctt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_item,
	output logic      full,
	output logic      pop_valid,
	output item_t     pop_item
);
	item_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	// the back end takes an entry whenever one is there
	assign pop       = (count_q != 2'd0);
	assign pop_valid = pop;
	assign pop_item  = mem_q[rd_ptr_q];
	assign full      = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[hdl/tctt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, one transaction per cycle,
// and a pipelined divide-by-1000 built from 16-bit digit steps.
// tctt_div needs no package; tctt_div1000 takes its constants from tctt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tctt_div #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 34,
	parameter int unsigned SW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [NW-1:0]      quot,
	output logic [DW-1:0]      rem,
	output logic [DW-1:0]      divisor_out,
	output logic [SW-1:0]      side_out
);
	logic          v_s  [0:NW];
	logic [DW-1:0] r_s  [0:NW];
	logic [NW-1:0] nq_s [0:NW];
	logic [DW-1:0] d_s  [0:NW];
	logic [SW-1:0] sb_s [0:NW];

	assign v_s[0]  = in_valid;
	assign r_s[0]  = '0;
	assign nq_s[0] = dividend;
	assign d_s[0]  = divisor;
	assign sb_s[0] = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] r_ext, r_sub;
		logic        ge;

		// shift in the next dividend bit, subtract where it fits
		assign r_ext = {r_s[i], nq_s[i][NW-1]};
		assign r_sub = r_ext - {1'b0, d_s[i]};
		assign ge    = (r_ext >= {1'b0, d_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else         v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			r_s[i+1]  <= ge ? r_sub[DW-1:0] : r_ext[DW-1:0];
			nq_s[i+1] <= {nq_s[i][NW-2:0], ge};
			d_s[i+1]  <= d_s[i];
			sb_s[i+1] <= sb_s[i];
		end
	end

	assign out_valid   = v_s[NW];
	assign quot        = nq_s[NW];
	assign rem         = r_s[NW];
	assign divisor_out = d_s[NW];
	assign side_out    = sb_s[NW];
endmodule

// Divide a 64-bit value by 1000: four steps of one 16-bit quotient digit each.
// A step is a reciprocal multiply, then the remainder fix-up, each registered.
module tctt_div1000
	import tctt_pkg::*;
#(
	parameter int unsigned SW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [63:0]   dividend,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [63:0]        quot,
	output logic [SW-1:0]      side_out
);
	logic          v_s  [0:4];
	logic [63:0]   n_s  [0:4];
	logic [63:0]   q_s  [0:4];
	logic [9:0]    r_s  [0:4];
	logic [SW-1:0] sb_s [0:4];

	assign v_s[0]  = in_valid;
	assign n_s[0]  = dividend;
	assign q_s[0]  = '0;
	assign r_s[0]  = '0;
	assign sb_s[0] = side_in;

	for (genvar i = 0; i < 4; i++) begin : g_step
		logic [25:0]   x, rd;
		logic [51:0]   prod;
		logic          v_s1;
		logic [25:0]   x_s1;
		logic [15:0]   qd_s1;
		logic [63:0]   n_s1, q_s1;
		logic [SW-1:0] sb_s1;

		// running remainder joined with the next digit, quotient digit by reciprocal
		assign x    = {r_s[i], n_s[i][63:48]};
		assign prod = 52'(x) * 52'(US_RECIP);
		// remainder left for the next digit
		assign rd   = x_s1 - 26'(qd_s1) * 26'(NS_PER_US);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1     <= 1'b0;
				v_s[i+1] <= 1'b0;
			end else begin
				v_s1     <= v_s[i];
				v_s[i+1] <= v_s1;
			end
		end

		always_ff @(posedge clk) begin
			x_s1      <= x;
			qd_s1     <= prod[51:36];
			n_s1      <= {n_s[i][47:0], 16'h0000};
			q_s1      <= q_s[i];
			sb_s1     <= sb_s[i];
			r_s[i+1]  <= rd[9:0];
			q_s[i+1]  <= {q_s1[47:0], qd_s1};
			n_s[i+1]  <= n_s1;
			sb_s[i+1] <= sb_s1;
		end
	end

	assign out_valid = v_s[4];
	assign quot      = q_s[4];
	assign side_out  = sb_s[4];
endmodule
`default_nettype wire

[hdl/tctt_back.sv]
// Back end: seconds split, nanosecond assembly, microsecond and millisecond division.
// Depends on tctt_pkg, tctt_div and tctt_div1000.
`timescale 1ns / 1ps
`default_nettype none
module tctt_back
	import tctt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  item_t                  in_item,
	output logic                   done,
	output logic [DATA_W-1:0]      elapsed_ticks,
	output logic [DATA_W-1:0]      elapsed_ns,
	output logic [DATA_W-1:0]      elapsed_us,
	output logic [DATA_W-1:0]      elapsed_ms
);
	logic                   v1;
	logic [COUNT_WIDTH-1:0] q1;
	logic [RATE_W-1:0]      r1, d1;
	logic [DATA_W-1:0]      t1, secs;

	logic              v_m1, v_m2, v2, v_a, v3;
	logic [DATA_W-1:0] plo_m1, prem_m1, ticks_m1;
	logic [31:0]       phi_m1;
	logic [RATE_W-1:0] rate_m1, rate_m2;
	logic [DATA_W-1:0] whole_m2, prem_m2, ticks_m2;
	logic [DATA_W-1:0] q2, t2, w2, ns_a, ticks_a, us3;
	logic [2*DATA_W-1:0] sb2, sb3;
	logic [3*DATA_W-1:0] sb4;

	// whole seconds and leftover ticks
	tctt_div #(.NW(COUNT_WIDTH), .DW(RATE_W), .SW(DATA_W)) u_div_sec (
		.clk, .arst_n,
		.in_valid(in_valid), .dividend(in_item.ticks[COUNT_WIDTH-1:0]),
		.divisor(in_item.rate), .side_in(in_item.ticks),
		.out_valid(v1), .quot(q1), .rem(r1), .divisor_out(d1), .side_out(t1)
	);

	assign secs = DATA_W'(q1);

	// partial products of seconds * 1e9 and remainder * 1e9
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_a  <= 1'b0;
		end else begin
			v_m1 <= v1;
			v_m2 <= v_m1;
			v_a  <= v2;
		end
	end

	always_ff @(posedge clk) begin
		plo_m1   <= DATA_W'(secs[31:0]) * DATA_W'(NS_PER_SEC);
		phi_m1   <= secs[63:32] * 32'(NS_PER_SEC);
		prem_m1  <= DATA_W'(r1) * DATA_W'(NS_PER_SEC);
		rate_m1  <= d1;
		ticks_m1 <= t1;
		// whole-second nanoseconds, modulo 2^64
		whole_m2 <= plo_m1 + {phi_m1, 32'b0};
		prem_m2  <= prem_m1;
		rate_m2  <= rate_m1;
		ticks_m2 <= ticks_m1;
		// total nanoseconds
		ns_a    <= w2 + q2;
		ticks_a <= t2;
	end

	// fractional-second nanoseconds
	tctt_div #(.NW(DATA_W), .DW(RATE_W), .SW(2*DATA_W)) u_div_frac (
		.clk, .arst_n,
		.in_valid(v_m2), .dividend(prem_m2), .divisor(rate_m2),
		.side_in({ticks_m2, whole_m2}),
		.out_valid(v2), .quot(q2), .rem(), .divisor_out(), .side_out(sb2)
	);
	assign t2 = sb2[2*DATA_W-1:DATA_W];
	assign w2 = sb2[DATA_W-1:0];

	// microseconds from nanoseconds
	tctt_div1000 #(.SW(2*DATA_W)) u_div_us (
		.clk, .arst_n,
		.in_valid(v_a), .dividend(ns_a), .side_in({ticks_a, ns_a}),
		.out_valid(v3), .quot(us3), .side_out(sb3)
	);

	// milliseconds as microseconds over 1000 (nested truncation is exact)
	tctt_div1000 #(.SW(3*DATA_W)) u_div_ms (
		.clk, .arst_n,
		.in_valid(v3), .dividend(us3), .side_in({sb3, us3}),
		.out_valid(done), .quot(elapsed_ms), .side_out(sb4)
	);

	assign elapsed_ticks = sb4[3*DATA_W-1:2*DATA_W];
	assign elapsed_ns    = sb4[2*DATA_W-1:DATA_W];
	assign elapsed_us    = sb4[DATA_W-1:0];
endmodule
`default_nettype wire

[hdl/tick_count_to_time_core.sv]
// Converts timestamp counter readings to elapsed ticks, ns, us and ms since a start count.
// A reading is taken on any cycle with start high and busy low, one per cycle sustained;
// busy never rises, as the back end drains the queue every cycle. The result shows on the
// done strobe COUNT_WIDTH + 83 cycles after the accepting edge (queue write at that edge,
// then COUNT_WIDTH + 64 divider stages for the seconds split and the fraction, three
// arithmetic register stages, and sixteen cycles for the two divisions by 1000), in
// order, for a single cycle, and must be captured then. Registers are written with
// cfg_we/cfg_index/cfg_wdata while no reading is in flight.
// Depends on tctt_pkg, tctt_front, tctt_queue, tctt_back.
`timescale 1ns / 1ps
`default_nettype none
module tick_count_to_time_core
	import tctt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [DATA_W-1:0] cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [DATA_W-1:0] counter_value,
	output logic                   done,
	output logic [DATA_W-1:0]      elapsed_ticks,
	output logic [DATA_W-1:0]      elapsed_ns,
	output logic [DATA_W-1:0]      elapsed_us,
	output logic [DATA_W-1:0]      elapsed_ms
);
	item_t front_item, back_item;
	logic  back_valid, full;

	tctt_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata, .counter_value,
		.item(front_item)
	);

	tctt_queue u_queue (
		.clk, .arst_n, .push(start & ~full), .push_item(front_item),
		.full(full), .pop_valid(back_valid), .pop_item(back_item)
	);

	assign busy = full;

	tctt_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk, .arst_n, .in_valid(back_valid), .in_item(back_item),
		.done, .elapsed_ticks, .elapsed_ns, .elapsed_us, .elapsed_ms
	);
endmodule
`default_nettype wire

[hdl/tctt_checker.sv]
// Port-level checks for tick_count_to_time_core, bound to the top level.
// Depends on tick_count_to_time_core.
`timescale 1ns / 1ps
`default_nettype none
module tctt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [63:0] elapsed_ns,
	input wire logic [63:0] elapsed_us,
	input wire logic [63:0] elapsed_ms
);
	// the back end drains every cycle, so the queue never fills
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// coarser units never exceed finer ones
	a_us_le_ns: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (elapsed_us <= elapsed_ns))
		else $error("us above ns");

	a_ms_le_us: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (elapsed_ms <= elapsed_us))
		else $error("ms above us");
endmodule

bind tick_count_to_time_core tctt_checker u_tctt_checker (
	.clk, .arst_n, .busy, .done, .elapsed_ns, .elapsed_us, .elapsed_ms
);
`default_nettype wire

[sim/tick_count_to_time_core_test.sv]
// Testbench for tick_count_to_time_core: directed and random counter readings
// checked against an in-bench conversion model. Depends on tctt_pkg and the core.
`timescale 1ns / 1ps
`default_nettype none
module tick_count_to_time_core_test;
	import tctt_pkg::*;

	localparam int unsigned LATENCY = 64 + 83;

	typedef struct {
		logic [DATA_W-1:0] ticks;
		logic [DATA_W-1:0] ns;
		logic [DATA_W-1:0] us;
		logic [DATA_W-1:0] ms;
	} time_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_START_COUNT;
	logic [DATA_W-1:0] cfg_wdata = '0;
	logic              start = 1'b0;
	logic              busy;
	logic [DATA_W-1:0] counter_value = '0;
	logic              done;
	logic [DATA_W-1:0] elapsed_ticks, elapsed_ns, elapsed_us, elapsed_ms;

	logic [DATA_W-1:0] model_start = '0;
	logic [RATE_W-1:0] model_rate = RATE_RESET;
	time_t             pending_times[$];
	int                error_count = 0;

	tick_count_to_time_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy),
		.counter_value(counter_value), .done(done), .elapsed_ticks(elapsed_ticks),
		.elapsed_ns(elapsed_ns), .elapsed_us(elapsed_us), .elapsed_ms(elapsed_ms)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tick_count_to_time_core_test: done, errors");
		$finish;
	end

	// conversion of one reading with the current settings
	function automatic time_t convert_reading(logic [DATA_W-1:0] reading);
		time_t             t;
		logic [DATA_W-1:0] rate, secs, rem;
		rate = (model_rate == 0) ? 64'd1 : DATA_W'(model_rate);
		t.ticks = reading - model_start;
		secs = t.ticks / rate;
		rem = t.ticks % rate;
		t.ns = secs * 64'd1000000000 + (rem * 64'd1000000000) / rate;
		t.us = t.ns / 64'd1000;
		t.ms = t.ns / 64'd1000000;
		return t;
	endfunction

	// result checker: each strobe takes the oldest expectation
	always @(posedge clk) begin
		time_t exp_t;
		if (done) begin
			if (pending_times.size() == 0) begin
				$error("result with no transaction waiting");
				error_count++;
			end else begin
				exp_t = pending_times.pop_front();
				if (elapsed_ticks !== exp_t.ticks) begin
					$error("elapsed_ticks exp %h got %h", exp_t.ticks, elapsed_ticks);
					error_count++;
				end
				if (elapsed_ns !== exp_t.ns) begin
					$error("elapsed_ns exp %h got %h", exp_t.ns, elapsed_ns);
					error_count++;
				end
				if (elapsed_us !== exp_t.us) begin
					$error("elapsed_us exp %h got %h", exp_t.us, elapsed_us);
					error_count++;
				end
				if (elapsed_ms !== exp_t.ms) begin
					$error("elapsed_ms exp %h got %h", exp_t.ms, elapsed_ms);
					error_count++;
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// idle length: mostly short, now and then long, often none
	function automatic int gap_cycles();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		return n;
	endfunction

	// send one reading; start stays high across back-to-back transactions
	task automatic send_reading(logic [DATA_W-1:0] reading, bit gap);
		int n;
		start <= 1'b1;
		counter_value <= reading;
		do @(posedge clk); while (busy);
		pending_times.push_back(convert_reading(reading));
		if (gap) begin
			n = gap_cycles();
			if (n != 0) begin
				start <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_times.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// one write, then the write port goes quiet before the task returns
	task automatic write_reg(logic index, logic [DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (index == REG_START_COUNT) model_start = value;
		else model_rate = value[RATE_W-1:0];
	endtask

	task automatic test_reset_values();
		send_reading(64'd0, 0);
		send_reading(64'd999999999, 0);
		send_reading(64'd1000000000, 0);
		send_reading('1, 1);
		wait_drained();
	endtask

	task automatic test_field_extremes();
		write_reg(REG_START_COUNT, 64'd5);
		write_reg(REG_TICK_RATE, 64'd1);
		send_reading(64'd4, 0);  // wraps below start
		send_reading(64'd5, 0);
		send_reading('1, 1);
		wait_drained();
		write_reg(REG_TICK_RATE, 64'd0);  // zero rate acts as one
		send_reading(64'd123, 0);
		send_reading('1, 1);
		wait_drained();
		write_reg(REG_START_COUNT, '1);
		write_reg(REG_TICK_RATE, '1);  // upper bits dropped
		send_reading(64'd0, 0);
		send_reading('1, 0);
		send_reading(64'h0000_0003_FFFF_FFFE, 0);
		send_reading(64'h8000_0000_0000_0000, 1);
		wait_drained();
		write_reg(REG_START_COUNT, 64'd0);
		write_reg(REG_TICK_RATE, 64'd3);
		send_reading(64'd2, 0);
		send_reading(64'h5555_5555_5555_5555, 0);
		send_reading('1, 1);
		wait_drained();
	endtask

	task automatic test_random_settings();
		logic [DATA_W-1:0] rate;
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_START_COUNT, rand64());
			case (phase % 4)
				0: rate = {$urandom(), $urandom()};
				1: rate = $urandom_range(1, 1000);
				2: rate = 64'd1000000000 + $urandom_range(0, 1000);
				default: rate = {30'd0, 2'b11, $urandom()};
			endcase
			write_reg(REG_TICK_RATE, rate);
			for (int k = 0; k < 100; k++) begin
				send_reading(($urandom_range(0, 3) == 0) ? model_start + $urandom() :
					rand64(), $urandom_range(0, 1));
			end
			wait_drained();
		end
		// hold-off until every result is back, then a sustained burst
		for (int k = 0; k < 50; k++) send_reading(rand64(), 0);
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_random_settings();
		if (error_count == 0) begin
			$display("tick_count_to_time_core_test: done, clean");
		end else begin
			$display("tick_count_to_time_core_test: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
